[rtl/lchct_pkg.sv]
// ---------------------------------------------------------------------------
// lchct_pkg: shared constants for the LRU cache hit cost tracker
// Field widths, access costs and parameter defaults.
// ---------------------------------------------------------------------------
`default_nettype none

package lchct_pkg;

  localparam int KEY_W   = 64;
  localparam int CFG_W   = 6;
  localparam int COST_W  = 3;
  localparam int TOTAL_W = 32;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int TAG_BITS_DEF    = 64;

  localparam logic [COST_W-1:0] HIT_COST  = 3'd1;
  localparam logic [COST_W-1:0] MISS_COST = 3'd5;

endpackage

`default_nettype wire

[rtl/lchct_cell.sv]
// ---------------------------------------------------------------------------
// lchct_cell: one recency slot of the LRU chain
// Holds a tag and a valid bit, compares against the broadcast key and takes
// its upstream neighbor's contents when the recency shift reaches it.
// ---------------------------------------------------------------------------
`default_nettype none

module lchct_cell #(
  parameter int TAG_W    = 64,
  parameter int IDX_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [TAG_W-1:0] key,
  input  wire logic             cmp_en,
  input  wire logic             shift_req,
  input  wire logic [IDX_W-1:0] shift_pos,
  input  wire logic [TAG_W-1:0] prev_tag,
  input  wire logic             prev_valid,
  output logic      [TAG_W-1:0] tag,
  output logic                  valid,
  output logic                  match
);

  localparam logic [IDX_W-1:0] CELL_IDX_C = IDX_W'(CELL_IDX);

  logic shift_en;

  // Every slot at or below the shift position moves one step toward the end.
  assign shift_en = shift_req && (CELL_IDX_C <= shift_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (cmp_en) begin
        match <= valid && (tag == key);
      end
      if (shift_en) begin
        valid <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      tag <= prev_tag;
    end
  end

endmodule

`default_nettype wire

[rtl/lru_cache_hit_cost_tracker_top.sv]
// ---------------------------------------------------------------------------
// lru_cache_hit_cost_tracker_top: fully associative LRU cache cost counter
// Looks each request key up in an LRU ordered chain of slots and reports the
// hit flag, the access cost and a saturating running total.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: request_key with in_valid / in_ready. One word per lookup.
//   Output channel: was_hit, access_cost, running_total with out_valid /
//   out_ready. Exactly one result word per request word, in order.
//   Configuration: cfg_wr_en writes cfg_wr_data into the cache size register
//   in the same cycle; write it only while no lookup is in flight.
//   Order: an accepted key is registered, compared with all slots of the
//   chain in the compare state, and then the update state shifts the chain
//   to move the entry to the front and registers the result; the next key
//   can be taken while that update fires, before the result is read out.
//   Stall: a result word held by a stalled receiver does not block the next
//   request, but the following update waits until the output register frees.
//   Reset: the synchronous reset empties the cache, clears the total and sets
//   the cache size to zero.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_cache_hit_cost_tracker_top #(
  parameter int MAX_ENTRIES = lchct_pkg::MAX_ENTRIES_DEF,
  parameter int TAG_BITS    = lchct_pkg::TAG_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lchct_pkg::CFG_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lchct_pkg::KEY_W-1:0]   request_key,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               was_hit,
  output logic      [lchct_pkg::COST_W-1:0]  access_cost,
  output logic      [lchct_pkg::TOTAL_W-1:0] running_total
);

  import lchct_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int SZ_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]    cache_size;
  logic [TAG_BITS-1:0] key;
  logic [OCC_W-1:0]    occ;

  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic [TAG_BITS-1:0]    tag_arr [MAX_ENTRIES];

  logic             in_fire;
  logic             upd_fire;
  logic             hit_any;
  logic [IDX_W-1:0] hit_pos;
  logic [SZ_W-1:0]  size_eff;
  logic [SZ_W-1:0]  occ_ext;
  logic             has_room;
  logic             shift_req;
  logic [IDX_W-1:0] shift_pos;
  logic [COST_W-1:0] cost;
  logic [TOTAL_W:0]  total_sum;

  assign upd_fire = (state == ST_UPD) && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) || upd_fire;
  assign in_fire  = in_valid && in_ready;

  // Row of slots: slot 0 is the most recent, each slot feeds the next one.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [TAG_BITS-1:0] prev_tag;
    logic                prev_valid;

    if (i == 0) begin : g_head
      assign prev_tag   = key;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_tag   = tag_arr[i-1];
      assign prev_valid = valid_vec[i-1];
    end

    lchct_cell #(
      .TAG_W    (TAG_BITS),
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .key        (key),
      .cmp_en     (state == ST_CMP),
      .shift_req  (shift_req),
      .shift_pos  (shift_pos),
      .prev_tag   (prev_tag),
      .prev_valid (prev_valid),
      .tag        (tag_arr[i]),
      .valid      (valid_vec[i]),
      .match      (match_vec[i])
    );
  end

  // At most one slot matches, so the position is an OR of the slot indexes.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
      end
    end
  end

  assign hit_any  = |match_vec;
  assign size_eff = (SZ_W'(cache_size) > SZ_W'(MAX_ENTRIES)) ? SZ_W'(MAX_ENTRIES)
                                                             : SZ_W'(cache_size);
  assign occ_ext  = SZ_W'(occ);
  assign has_room = occ_ext < size_eff;

  // A hit moves the matching slot to the front. A miss fills the first empty
  // slot if there is room, else pushes out the last occupied slot if size != 0.
  always_comb begin
    shift_req = 1'b0;
    shift_pos = '0;
    if (upd_fire) begin
      if (hit_any) begin
        shift_req = 1'b1;
        shift_pos = hit_pos;
      end else if (has_room) begin
        shift_req = 1'b1;
        shift_pos = occ[IDX_W-1:0];
      end else if (size_eff != '0) begin
        shift_req = 1'b1;
        shift_pos = IDX_W'(occ - OCC_W'(1));
      end
    end
  end

  assign cost      = hit_any ? HIT_COST : MISS_COST;
  assign total_sum = {1'b0, running_total} + (TOTAL_W + 1)'(cost);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (upd_fire) begin
          state_next = in_fire ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cache_size    <= '0;
      occ           <= '0;
      out_valid     <= 1'b0;
      running_total <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        cache_size <= cfg_wr_data;
      end
      if (upd_fire) begin
        out_valid <= 1'b1;
        if (total_sum[TOTAL_W]) begin
          running_total <= '1;
        end else begin
          running_total <= total_sum[TOTAL_W-1:0];
        end
        if (!hit_any && has_room) begin
          occ <= occ + OCC_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key <= request_key[TAG_BITS-1:0];
    end
    if (upd_fire) begin
      was_hit     <= hit_any;
      access_cost <= cost;
    end
  end

  // A key is stored at most once, so no two slots can match together.
  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("more than one slot matched the key");

  // Occupied slots always form an unbroken run from the front of the chain.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + MAX_ENTRIES'(1))) == '0)
    else $error("occupied slots are not contiguous from the front");

  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(occ))
    else $error("occupancy count disagrees with the valid bits");

  a_accept_cmp: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_CMP))
    else $error("accepted word did not start a compare");

endmodule

`default_nettype wire

[sim/tb_lru_cache_hit_cost_tracker_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lru_cache_hit_cost_tracker_top: testbench for the LRU cache cost tracker
// Drives request keys through the valid/ready input channel and checks each
// result word against a behavioral LRU cache kept in the testbench. Cache
// sizes are switched between phases, with random idling on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_lru_cache_hit_cost_tracker_top;
  import lchct_pkg::*;

  localparam int SLOTS       = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic               hit;
    logic [COST_W-1:0]  cost;
    logic [TOTAL_W-1:0] total;
  } lookup_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KEY_W-1:0]   request_key = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               was_hit;
  logic [COST_W-1:0]  access_cost;
  logic [TOTAL_W-1:0] running_total;

  // Behavioral copy of the cache.
  logic [KEY_W-1:0]   slot_tag [SLOTS];
  bit                 slot_valid [SLOTS];
  int unsigned        slot_age [SLOTS];
  int unsigned        occupancy;
  logic [TOTAL_W-1:0] cost_sum;
  logic [CFG_W-1:0]   cache_size_q;

  lookup_result_t     pending_results [$];
  logic [KEY_W-1:0]   key_pool [$];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  bit                 quiet = 1'b0;

  lru_cache_hit_cost_tracker_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .request_key   (request_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .was_hit       (was_hit),
    .access_cost   (access_cost),
    .running_total (running_total)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 9);
  end

  // Make one slot the most recent; every valid slot younger than limit ages.
  function automatic void make_recent(int slot, int unsigned limit);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_valid[i] && i != slot && slot_age[i] < limit) slot_age[i]++;
    end
    slot_age[slot] = 0;
  endfunction

  function automatic lookup_result_t predict_lookup(logic [KEY_W-1:0] key);
    lookup_result_t r;
    int unsigned    size;
    int             hit_slot;
    int             pick;
    int unsigned    oldest;
    size     = (int'(cache_size_q) > SLOTS) ? SLOTS : int'(cache_size_q);
    hit_slot = -1;
    pick     = -1;
    oldest   = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_slot < 0 && slot_valid[i] && slot_tag[i] == key) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      make_recent(hit_slot, slot_age[hit_slot]);
      r.cost = HIT_COST;
    end else begin
      r.cost = MISS_COST;
      if (occupancy < size) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (pick < 0 && !slot_valid[i]) pick = i;
        end
        if (pick >= 0) begin
          slot_valid[pick] = 1'b1;
          slot_tag[pick]   = key;
          occupancy++;
          make_recent(pick, 32'hFFFF_FFFF);
        end
      end else if (size != 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && (pick < 0 || slot_age[i] > oldest)) begin
            pick   = i;
            oldest = slot_age[i];
          end
        end
        if (pick >= 0) begin
          slot_tag[pick] = key;
          make_recent(pick, 32'hFFFF_FFFF);
        end
      end
    end
    if (cost_sum > TOTAL_MAX - TOTAL_W'(r.cost)) cost_sum = TOTAL_MAX;
    else cost_sum = cost_sum + TOTAL_W'(r.cost);
    r.hit   = (hit_slot >= 0);
    r.total = cost_sum;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    $display("MISMATCH at cycle %0d: %s expected %0d got %0d",
             cycle_count, what, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin : result_checker
    lookup_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, running_total", 64'(0),
                        64'(running_total));
      end else begin
        exp_r = pending_results.pop_front();
        if (was_hit !== exp_r.hit)
          report_mismatch("was_hit", 64'(exp_r.hit), 64'(was_hit));
        if (access_cost !== exp_r.cost)
          report_mismatch("access_cost", 64'(exp_r.cost), 64'(access_cost));
        if (running_total !== exp_r.total)
          report_mismatch("running_total", 64'(exp_r.total), 64'(running_total));
      end
    end
  end

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_key(input logic [KEY_W-1:0] key);
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 9);
    end
    in_valid    <= 1'b1;
    request_key <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_lookup(key));
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cache_size(input logic [CFG_W-1:0] size);
    wait_all_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    cache_size_q = size;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  task automatic test_size_zero();
    send_key('0);
    send_key('1);
    send_key('0);
    send_key('1);
  endtask

  task automatic test_lru_order();
    logic [KEY_W-1:0] a, b, c;
    a = random_key();
    b = '1;
    c = '0;
    set_cache_size(6'd2);
    send_key(a);
    send_key(b);
    send_key(a);
    send_key(c);  // evicts b, the least recent
    send_key(b);
    send_key(a);
    send_key(b);
  endtask

  task automatic test_size_lowered();
    logic [KEY_W-1:0] a, b, c;
    a = random_key();
    b = random_key();
    c = random_key();
    set_cache_size(6'd3);
    send_key(a);
    send_key(b);
    send_key(c);
    // The stored entries survive the smaller size and still hit.
    set_cache_size(6'd1);
    send_key(a);
    send_key(random_key());
    send_key(c);
    send_key(a);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] size, input int count,
                           input bit pause_midway);
    int pool_len;
    set_cache_size(size);
    pool_len = (int'(size) > SLOTS ? SLOTS : int'(size)) * 5 / 4 + 2;
    key_pool.delete();
    for (int i = 0; i < pool_len; i++) key_pool.push_back(random_key());
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) wait_all_results();
      if ($urandom_range(99) < 85)
        send_key(key_pool[$urandom_range(key_pool.size() - 1)]);
      else
        send_key(random_key());
    end
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] sizes [10];
    sizes = '{6'd32, 6'd63, 6'd3, 6'd1, 6'd0, 6'd40, 6'd8, 6'd32, 6'd2, 6'd17};
    foreach (sizes[p]) begin
      quiet = (p == 5);
      run_phase(sizes[p], 85, p == 2);
    end
    quiet = 1'b0;
    run_phase(CFG_W'($urandom_range(0, 63)), 40, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_tag[i]   = '0;
      slot_valid[i] = 1'b0;
      slot_age[i]   = 0;
    end
    occupancy    = 0;
    cost_sum     = '0;
    cache_size_q = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_size_zero();
    test_lru_order();
    test_size_lowered();
    test_random_phases();

    wait_all_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
